FILE: rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants for the chunked body decoder
// Character codes, decoder phases, error codes, state flags and the
// response payload layout used by the decoder modules.
// ----------------------------------------------------------------------------
package chd_pkg;

   // Default width of the chunk size accumulator
   localparam int SIZE_BITS_DEFAULT = 64;

   // Character codes
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Decoder phases
   typedef enum logic [3:0] {
      PH_SIZE,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_TRAILER,
      PH_DONE
   } phase_type;

   // Sticky error codes
   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_EMPTY_SIZE,
      ERR_NOT_HEX,
      ERR_SIZE_OVERFLOW,
      ERR_BAD_TRAILER,
      ERR_NO_CRLF
   } err_type;

   // Decoder state apart from the size counter
   typedef struct packed {
      phase_type phase;
      logic      digit_seen;
      logic      digits_ended;
      logic      pending_cr;
      logic      line_has_content;
      logic      colon_seen;
      err_type   error_held;
   } flags_type;

   // One response item
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       body_done;
      logic [2:0] error_code;
   } result_type;

   // Hex digit decode: bit 4 set when c is a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

FILE: rtl/chd_req_if.sv
// ----------------------------------------------------------------------------
// chd_req_if: request channel of the chunked body decoder
// Valid/ready handshake carrying one byte of the chunked stream.
// ----------------------------------------------------------------------------
interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/chd_rsp_if.sv
// ----------------------------------------------------------------------------
// chd_rsp_if: response channel of the chunked body decoder
// Valid/ready handshake carrying one decoded result per request.
// ----------------------------------------------------------------------------
interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       body_done;
   logic [2:0] error_code;

   modport source (output valid, output payload_valid, output payload_byte,
                   output body_done, output error_code, input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input body_done, input error_code, output ready);
endinterface

FILE: rtl/chd_step.sv
// ----------------------------------------------------------------------------
// chd_step: next-state and result logic for one stream byte
// Size line parsing, chunk data countdown, data CR LF check and trailer
// line checks, all in one combinational pass.
// ----------------------------------------------------------------------------
module chd_step #(
   parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
   input  chd_pkg::flags_type  cur_flags,
   input  logic [SIZE_BITS-1:0] cur_count,
   input  logic [7:0]           in_byte,
   output chd_pkg::flags_type  nxt_flags,
   output logic [SIZE_BITS-1:0] nxt_count,
   output chd_pkg::result_type result
);

   typedef struct packed {
      chd_pkg::flags_type   f;
      logic [SIZE_BITS-1:0] cnt;
   } st_type;

   // One ordinary byte of a size or trailer line
   function automatic st_type line_byte(st_type s, logic [7:0] c);
      st_type     r;
      logic [4:0] h;
      r = s;
      h = chd_pkg::hex_nibble(c);
      if (s.f.error_held == chd_pkg::ERR_NONE) begin
         if (s.f.phase == chd_pkg::PH_SIZE) begin
            if (!s.f.digits_ended) begin
               if (h[4]) begin
                  if (s.cnt[SIZE_BITS-1 -: 4] != 4'd0) begin
                     r.f.error_held = chd_pkg::ERR_SIZE_OVERFLOW;
                  end else begin
                     r.cnt = {s.cnt[SIZE_BITS-5:0], h[3:0]};
                     r.f.digit_seen = 1'b1;
                  end
               end else if (!s.f.digit_seen) begin
                  if (c != chd_pkg::CH_SPACE && c != chd_pkg::CH_TAB) begin
                     r.f.error_held = (c == chd_pkg::CH_SEMI) ?
                        chd_pkg::ERR_EMPTY_SIZE : chd_pkg::ERR_NOT_HEX;
                  end
               end else begin
                  r.f.digits_ended = 1'b1;
               end
            end
         end else begin
            r.f.line_has_content = 1'b1;
            if (c == chd_pkg::CH_COLON) begin
               r.f.colon_seen = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // CR LF closing a size or trailer line
   function automatic st_type line_end(st_type s);
      st_type r;
      r = s;
      if (s.f.error_held == chd_pkg::ERR_NONE) begin
         if (s.f.phase == chd_pkg::PH_SIZE) begin
            if (!s.f.digit_seen) begin
               r.f.error_held = chd_pkg::ERR_EMPTY_SIZE;
            end else begin
               r.f.phase = (s.cnt != '0) ? chd_pkg::PH_DATA : chd_pkg::PH_TRAILER;
               r.f.digit_seen = 1'b0;
               r.f.digits_ended = 1'b0;
            end
         end else if (s.f.line_has_content && !s.f.colon_seen) begin
            r.f.error_held = chd_pkg::ERR_BAD_TRAILER;
         end else begin
            if (!s.f.line_has_content) begin
               r.f.phase = chd_pkg::PH_DONE;
            end
            r.f.line_has_content = 1'b0;
            r.f.colon_seen = 1'b0;
         end
      end
      return r;
   endfunction

   st_type               st;
   logic                 pay_valid;
   logic [7:0]           pay_byte;
   logic [SIZE_BITS-1:0] cnt_dec;

   assign cnt_dec = cur_count - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   // Per-phase byte handling
   always_comb begin
      st.f = cur_flags;
      st.cnt = cur_count;
      pay_valid = 1'b0;
      pay_byte = 8'h00;
      if (cur_flags.error_held == chd_pkg::ERR_NONE) begin
         case (cur_flags.phase)
            chd_pkg::PH_DATA: begin
               pay_valid = 1'b1;
               pay_byte = in_byte;
               st.cnt = cnt_dec;
               if (cnt_dec == '0) begin
                  st.f.phase = chd_pkg::PH_DATA_CR;
               end
            end
            chd_pkg::PH_DATA_CR: begin
               if (in_byte == chd_pkg::CH_CR) st.f.phase = chd_pkg::PH_DATA_LF;
               else st.f.error_held = chd_pkg::ERR_NO_CRLF;
            end
            chd_pkg::PH_DATA_LF: begin
               if (in_byte == chd_pkg::CH_LF) st.f.phase = chd_pkg::PH_SIZE;
               else st.f.error_held = chd_pkg::ERR_NO_CRLF;
            end
            chd_pkg::PH_SIZE, chd_pkg::PH_TRAILER: begin
               if (cur_flags.pending_cr && in_byte == chd_pkg::CH_LF) begin
                  st.f.pending_cr = 1'b0;
                  st = line_end(st);
               end else begin
                  // a lone CR counts as an ordinary line byte
                  if (cur_flags.pending_cr) begin
                     st.f.pending_cr = 1'b0;
                     st = line_byte(st, chd_pkg::CH_CR);
                  end
                  if (in_byte == chd_pkg::CH_CR) st.f.pending_cr = 1'b1;
                  else st = line_byte(st, in_byte);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign nxt_flags = st.f;
   assign nxt_count = st.cnt;
   assign result.payload_valid = pay_valid;
   assign result.payload_byte = pay_byte;
   assign result.body_done = (st.f.error_held == chd_pkg::ERR_NONE) &&
                             (st.f.phase == chd_pkg::PH_DONE);
   assign result.error_code = st.f.error_held;

endmodule

FILE: rtl/http_chunked_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_decoder: HTTP/1.1 chunked transfer body decoder
// Takes the chunked body one byte per request and returns one result per
// request: a payload byte when the byte is chunk data, plus done and error.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one stream byte (in_byte) per request, valid/ready.
//  - rsp_bus returns exactly one result per request, in order: payload_valid
//    and payload_byte (0 unless valid), body_done, and the sticky error_code.
//  - A request lands in the input register at its accept edge, and its
//    result moves into the response register once that is free or draining.
//  - Throughput is one request per cycle unless rsp_bus stalls; the decode
//    state updates in the single pass between the input and response registers.
//  - When rsp_bus stalls, the response register holds and the input register
//    still takes one more request; req_bus.ready then drops until the
//    response is taken.
//  - Reset clears both register stages and returns the decoder to the start
//    of a size line with no error held.
//  - After an error or the final empty trailer line, later bytes are ignored
//    and the error code or body_done stays set.
// ----------------------------------------------------------------------------
module http_chunked_decoder #(
   parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   chd_req_if.sink   req_bus,
   chd_rsp_if.source rsp_bus
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   chd_pkg::flags_type   flags_ff;
   chd_pkg::flags_type   flags_in;
   logic [SIZE_BITS-1:0] count_ff;
   logic [SIZE_BITS-1:0] count_in;
   logic                 rsp_valid_ff;
   chd_pkg::result_type  rsp_ff;
   chd_pkg::result_type  rsp_in;
   logic                 advance;

   // Input stage moves on when the response register is free or draining
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   chd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .cur_flags (flags_ff),
      .cur_count (count_ff),
      .in_byte   (in_byte_ff),
      .nxt_flags (flags_in),
      .nxt_count (count_in),
      .result    (rsp_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.in_byte;
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '{phase: chd_pkg::PH_SIZE, error_held: chd_pkg::ERR_NONE,
                       default: 1'b0};
         count_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
         count_ff <= count_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload_valid = rsp_ff.payload_valid;
   assign rsp_bus.payload_byte = rsp_ff.payload_byte;
   assign rsp_bus.body_done = rsp_ff.body_done;
   assign rsp_bus.error_code = rsp_ff.error_code;

endmodule

FILE: rtl/chd_check.sv
// ----------------------------------------------------------------------------
// chd_check: port-level checks for the chunked body decoder
// Watches the response channel for stall behavior, sticky errors, sticky
// completion and a zero payload byte when no payload is carried.
// ----------------------------------------------------------------------------
module chd_check (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       payload_valid,
   input logic [7:0] payload_byte,
   input logic       body_done,
   input logic [2:0] error_code
);

   logic [2:0] last_err_ff;
   logic       last_done_ff;

   // Track the last delivered error and completion status
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= chd_pkg::ERR_NONE;
         last_done_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_err_ff <= error_code;
         last_done_ff <= body_done;
      end
   end

   // A stalled response holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({payload_valid, payload_byte, body_done, error_code}))
      else $error("response changed while stalled");

   // No payload or completion while an error is held
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != chd_pkg::ERR_NONE |-> !payload_valid && !body_done)
      else $error("payload or done with error held");

   // Errors are sticky across responses
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_err_ff != chd_pkg::ERR_NONE |-> error_code == last_err_ff)
      else $error("held error changed");

   // Completion is sticky and ends the payload
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_done_ff |-> body_done && !payload_valid)
      else $error("done dropped or payload after done");

   // Payload byte is zero when no payload is carried
   a_pay_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !payload_valid |-> payload_byte == 8'h00)
      else $error("payload byte set without payload");

endmodule

bind http_chunked_decoder chd_check u_chd_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .payload_valid (rsp_bus.payload_valid),
   .payload_byte  (rsp_bus.payload_byte),
   .body_done     (rsp_bus.body_done),
   .error_code    (rsp_bus.error_code)
);

FILE: bench/http_chunked_decoder_tb.sv
// ----------------------------------------------------------------------------
// http_chunked_decoder_tb: self-checking bench for the chunked body decoder
// Streams a chunked body into the decoder one byte per request and checks
// every response against an in-bench decoder model. The body is built from
// decorated size lines, random payload, trailer lines and one randomly chosen
// ending: a clean finish or one of the sticky errors, followed by ignored
// bytes. Both channels idle at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module http_chunked_decoder_tb;

   localparam int SIZE_BITS  = chd_pkg::SIZE_BITS_DEFAULT;
   localparam int STREAM_LEN = 1950;
   localparam int IDLE_PCT   = 32;
   localparam string HEX_CHARS = "0123456789abcdefABCDEF";

   typedef enum int {COLON_ANY, COLON_NEEDED, COLON_BANNED} colon_rule_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chd_req_if req_bus ();
   chd_rsp_if rsp_bus ();

   http_chunked_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Decoder model state, at its reset values
   chd_pkg::phase_type   dec_phase    = chd_pkg::PH_SIZE;
   logic [SIZE_BITS-1:0] chunk_left   = '0;
   logic                 digit_seen   = 1'b0;
   logic                 digits_ended = 1'b0;
   logic                 cr_waiting   = 1'b0;
   logic                 line_busy    = 1'b0;
   logic                 colon_seen   = 1'b0;
   chd_pkg::err_type     err_state    = chd_pkg::ERR_NONE;

   chd_pkg::result_type expected_q[$];
   int         fail_count    = 0;
   int         sent_count    = 0;
   int         payload_count = 0;
   int         chunk_count   = 0;
   bit         steady        = 1'b0;
   string      end_case      = "none";

   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // One byte of a size or trailer line (not part of a CR LF line end)
   function automatic void line_char(logic [7:0] c);
      int h;
      h = hex_value(c);
      if (err_state != chd_pkg::ERR_NONE) return;
      if (dec_phase == chd_pkg::PH_SIZE) begin
         if (digits_ended) return;
         if (h >= 0) begin
            if (chunk_left[SIZE_BITS-1 -: 4] != 4'h0) begin
               err_state = chd_pkg::ERR_SIZE_OVERFLOW;
            end else begin
               chunk_left = {chunk_left[SIZE_BITS-5:0], h[3:0]};
               digit_seen = 1'b1;
            end
         end else if (!digit_seen) begin
            if (c == chd_pkg::CH_SEMI) begin
               err_state = chd_pkg::ERR_EMPTY_SIZE;
            end else if (c != chd_pkg::CH_SPACE && c != chd_pkg::CH_TAB) begin
               err_state = chd_pkg::ERR_NOT_HEX;
            end
         end else begin
            digits_ended = 1'b1;
         end
      end else begin
         line_busy = 1'b1;
         if (c == chd_pkg::CH_COLON) colon_seen = 1'b1;
      end
   endfunction

   // Advance the decoder model by one stream byte and return its response
   function automatic chd_pkg::result_type decode_byte(logic [7:0] b);
      chd_pkg::result_type r;
      r = '0;
      if (err_state == chd_pkg::ERR_NONE) begin
         case (dec_phase)
            chd_pkg::PH_DATA: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               chunk_left      = chunk_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};
               if (chunk_left == '0) dec_phase = chd_pkg::PH_DATA_CR;
            end
            chd_pkg::PH_DATA_CR: begin
               if (b == chd_pkg::CH_CR) dec_phase = chd_pkg::PH_DATA_LF;
               else err_state = chd_pkg::ERR_NO_CRLF;
            end
            chd_pkg::PH_DATA_LF: begin
               if (b == chd_pkg::CH_LF) dec_phase = chd_pkg::PH_SIZE;
               else err_state = chd_pkg::ERR_NO_CRLF;
            end
            chd_pkg::PH_SIZE, chd_pkg::PH_TRAILER: begin
               if (cr_waiting && b == chd_pkg::CH_LF) begin
                  // line end
                  cr_waiting = 1'b0;
                  if (dec_phase == chd_pkg::PH_SIZE) begin
                     if (!digit_seen) begin
                        err_state = chd_pkg::ERR_EMPTY_SIZE;
                     end else begin
                        if (chunk_left != '0) dec_phase = chd_pkg::PH_DATA;
                        else dec_phase = chd_pkg::PH_TRAILER;
                        digit_seen   = 1'b0;
                        digits_ended = 1'b0;
                     end
                  end else if (line_busy && !colon_seen) begin
                     err_state = chd_pkg::ERR_BAD_TRAILER;
                  end else begin
                     if (!line_busy) dec_phase = chd_pkg::PH_DONE;
                     line_busy  = 1'b0;
                     colon_seen = 1'b0;
                  end
               end else begin
                  // a CR not followed by LF is an ordinary line byte
                  if (cr_waiting) begin
                     cr_waiting = 1'b0;
                     line_char(chd_pkg::CH_CR);
                  end
                  if (b == chd_pkg::CH_CR) cr_waiting = 1'b1;
                  else line_char(b);
               end
            end
            default: ;
         endcase
      end
      r.body_done  = (err_state == chd_pkg::ERR_NONE && dec_phase == chd_pkg::PH_DONE);
      r.error_code = err_state;
      return r;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255, 0));
      end while (hex_value(c) >= 0 ||
                 c inside {chd_pkg::CH_CR, chd_pkg::CH_LF, chd_pkg::CH_SPACE,
                           chd_pkg::CH_TAB, chd_pkg::CH_SEMI});
      return c;
   endfunction

   // Send one request and record the response it should produce
   task automatic send_byte(input logic [7:0] b);
      chd_pkg::result_type r;
      while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = decode_byte(b);
      expected_q.push_back(r);
      if (r.payload_valid) payload_count++;
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_crlf();
      send_byte(chd_pkg::CH_CR);
      send_byte(chd_pkg::CH_LF);
   endtask

   // Random line text that never holds CR LF; colon presence per rule
   task automatic send_line_text(input int len, input colon_rule_type rule);
      logic [7:0] c;
      logic [7:0] prev;
      int         colon_at;
      prev     = 8'h00;
      colon_at = (rule == COLON_NEEDED) ? int'($urandom_range(len - 1, 0)) : -1;
      for (int i = 0; i < len; i++) begin
         c = 8'($urandom_range(255, 0));
         if (prev == chd_pkg::CH_CR && c == chd_pkg::CH_LF) c = "x";
         if (rule == COLON_BANNED && c == chd_pkg::CH_COLON) c = "k";
         if (i == colon_at) c = chd_pkg::CH_COLON;
         send_byte(c);
         prev = c;
      end
   endtask

   // Size line with random blanks, leading zeros, letter case and extension
   task automatic send_size_line(input int unsigned n);
      string      digits;
      logic [7:0] c;
      repeat ($urandom_range(2, 0))
         send_byte($urandom_range(1, 0) ? chd_pkg::CH_SPACE : chd_pkg::CH_TAB);
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) send_byte("0");
      digits = $sformatf("%0h", n);
      for (int i = 0; i < digits.len(); i++) begin
         c = digits[i];
         if (c >= "a" && $urandom_range(1, 0) == 1) c = c - 8'h20;
         send_byte(c);
      end
      if ($urandom_range(1, 0) == 1) begin
         // first non-hex byte ends the digits
         case ($urandom_range(4, 0))
            0: send_byte(chd_pkg::CH_SEMI);
            1: send_byte(chd_pkg::CH_SPACE);
            2: send_byte(chd_pkg::CH_TAB);
            3: send_byte(non_hex_byte());
            default: begin
               send_byte(chd_pkg::CH_CR);
               send_byte(non_hex_byte());
            end
         endcase
         send_line_text(int'($urandom_range(6, 0)), COLON_ANY);
      end
      send_crlf();
   endtask

   task automatic send_chunk(input int unsigned n);
      send_size_line(n);
      repeat (n) send_byte(8'($urandom_range(255, 0)));
      send_crlf();
      chunk_count++;
   endtask

   task automatic send_trailers();
      repeat ($urandom_range(3, 0)) begin
         send_line_text(int'($urandom_range(10, 1)), COLON_NEEDED);
         send_crlf();
      end
   endtask

   // Directed: blanks, leading zero, extension with lone CR, digits ended by
   // a lone CR, payload extremes and a CR inside the payload
   task automatic test_directed_chunks();
      logic [7:0] seq [21];
      seq = '{chd_pkg::CH_SPACE, chd_pkg::CH_TAB, "0", "1", chd_pkg::CH_SEMI, "a",
              chd_pkg::CH_CR, "b", chd_pkg::CH_CR, chd_pkg::CH_LF,
              8'hFF, chd_pkg::CH_CR, chd_pkg::CH_LF,
              "2", chd_pkg::CH_CR, chd_pkg::CH_CR, chd_pkg::CH_LF,
              8'h00, chd_pkg::CH_CR, chd_pkg::CH_CR, chd_pkg::CH_LF};
      foreach (seq[i]) send_byte(seq[i]);
      chunk_count += 2;
   endtask

   // Random chunks, mostly short; a middle stretch runs with no idling
   task automatic test_random_chunks();
      int          start;
      int unsigned n;
      start = sent_count;
      while (sent_count < STREAM_LEN - 60) begin
         steady = (sent_count - start > 700) && (sent_count - start < 1000);
         n = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 17) : $urandom_range(16, 1);
         send_chunk(n);
      end
      steady = 1'b0;
   endtask

   // One way to end the body, then bytes the decoder must ignore
   task automatic test_body_end();
      int unsigned n;
      logic [7:0]  c;
      case ($urandom_range(5, 0))
         0: begin
            end_case = "clean end after trailers";
            send_size_line(0);
            send_trailers();
            send_crlf();
         end
         1: begin
            end_case = "empty size line";
            case ($urandom_range(2, 0))
               0: send_byte(chd_pkg::CH_SEMI);
               1: begin
                  repeat ($urandom_range(3, 1)) send_byte(chd_pkg::CH_SPACE);
                  send_crlf();
               end
               default: send_crlf();
            endcase
         end
         2: begin
            end_case = "non-hex size";
            send_byte(chd_pkg::CH_TAB);
            send_byte(non_hex_byte());
         end
         3: begin
            end_case = "size overflow";
            send_byte("0");
            send_byte("1");
            repeat (SIZE_BITS / 4) send_byte(HEX_CHARS[$urandom_range(21, 0)]);
         end
         4: begin
            end_case = "trailer line without colon";
            send_size_line(0);
            send_trailers();
            send_line_text(int'($urandom_range(8, 1)), COLON_BANNED);
            send_crlf();
         end
         default: begin
            end_case = "missing CR LF after data";
            n = $urandom_range(4, 1);
            send_size_line(n);
            repeat (n) send_byte(8'($urandom_range(255, 0)));
            c = 8'($urandom_range(255, 0));
            if ($urandom_range(1, 0) == 1) begin
               if (c == chd_pkg::CH_CR) c = 8'h00;
               send_byte(c);
            end else begin
               if (c == chd_pkg::CH_LF) c = 8'h00;
               send_byte(chd_pkg::CH_CR);
               send_byte(c);
            end
         end
      endcase
      repeat ($urandom_range(40, 20)) send_byte(8'($urandom_range(255, 0)));
   endtask

   // Response side stalls at random
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
   end

   // Compare each response with the oldest expected one
   always @(posedge clock) begin
      chd_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_bus.payload_valid !== want.payload_valid) begin
               $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                      rsp_bus.payload_valid);
               fail_count++;
            end
            if (rsp_bus.payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %02h, got %02h", want.payload_byte,
                      rsp_bus.payload_byte);
               fail_count++;
            end
            if (rsp_bus.body_done !== want.body_done) begin
               $error("body_done: expected %0d, got %0d", want.body_done, rsp_bus.body_done);
               fail_count++;
            end
            if (rsp_bus.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_bus.error_code);
               fail_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_chunks();
      test_random_chunks();
      test_body_end();
      req_bus.valid <= 1'b0;

      // drain, then let the pipeline settle
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Streamed %0d bytes in %0d chunks, %0d payload bytes out.",
               sent_count, chunk_count, payload_count);
      $display("Body ending exercised: %s.", end_case);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
